// ===== sv/ptt_pkg.sv =====
// Shared types and byte constants for the properties text tokenizer.
package ptt_pkg;

  localparam logic       CmdByte  = 1'b0;
  localparam logic       CmdEnd   = 1'b1;

  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSpace  = 8'h20;

  typedef struct packed {
    logic is_key;
    logic is_space;
    logic is_dot;
    logic is_eq;
    logic is_hash;
    logic is_nl;
    logic is_bslash;
  } class_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       in_key;
    logic       key_start;
    logic       key_part_end;
    logic       key_end;
    logic       value_end;
    logic       parse_error;
  } res_t;

endpackage

// ===== sv/ptt_classify.sv =====
// Byte classifier: key characters, whitespace and delimiters.
module ptt_classify (
  input  logic [7:0]          byte_i,
  output ptt_pkg::class_t     cls_o
);

  always_comb begin
    cls_o           = '0;
    cls_o.is_key    = (byte_i inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
                      (byte_i == ptt_pkg::ChUnder);
    cls_o.is_space  = byte_i inside {[8'd9:8'd13], ptt_pkg::ChSpace};
    cls_o.is_dot    = (byte_i == ptt_pkg::ChDot);
    cls_o.is_eq     = (byte_i == ptt_pkg::ChEq);
    cls_o.is_hash   = (byte_i == ptt_pkg::ChHash);
    cls_o.is_nl     = (byte_i == ptt_pkg::ChNl);
    cls_o.is_bslash = (byte_i == ptt_pkg::ChBslash);
  end

endmodule

// ===== sv/ptt_fsm.sv =====
// Parser state machine: mode, value-nonempty and sticky error, plus result decode.
module ptt_fsm (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            cmd_i,
  input  logic [7:0]      byte_i,
  input  ptt_pkg::class_t cls_i,
  output ptt_pkg::res_t   res_o
);

  typedef enum logic [2:0] {
    ModeLine    = 3'd0,
    ModeKey     = 3'd1,
    ModeKeySp   = 3'd2,
    ModeValue   = 3'd3,
    ModeEsc     = 3'd4,
    ModeComment = 3'd5
  } mode_e;

  mode_e mode_q, mode_d;
  logic  nonempty_q, nonempty_d;
  logic  err_q, err_d;
  logic  bad;
  ptt_pkg::res_t res;

  always_comb begin
    res        = '0;
    mode_d     = mode_q;
    nonempty_d = nonempty_q;
    err_d      = err_q;
    bad        = 1'b0;
    if (!err_q) begin
      if (cmd_i == ptt_pkg::CmdEnd) begin
        if (mode_q == ModeValue || mode_q == ModeEsc) begin
          res.value_end = 1'b1;
        end else if (mode_q == ModeKey || mode_q == ModeKeySp) begin
          bad = 1'b1;
        end
        if (!bad) begin
          mode_d     = ModeLine;
          nonempty_d = 1'b0;
        end
      end else begin
        case (mode_q)
          ModeKey: begin
            if (cls_i.is_dot) begin
              res.key_part_end = 1'b1;
              res.out_byte     = byte_i;
              res.byte_valid   = 1'b1;
              res.in_key       = 1'b1;
            end else if (cls_i.is_key) begin
              res.out_byte   = byte_i;
              res.byte_valid = 1'b1;
              res.in_key     = 1'b1;
            end else if (cls_i.is_space) begin
              res.key_part_end = 1'b1;
              res.key_end      = 1'b1;
              mode_d           = ModeKeySp;
            end else if (cls_i.is_eq) begin
              res.key_part_end = 1'b1;
              res.key_end      = 1'b1;
              mode_d           = ModeValue;
              nonempty_d       = 1'b0;
            end else begin
              bad = 1'b1;
            end
          end
          ModeKeySp: begin
            if (cls_i.is_eq) begin
              mode_d     = ModeValue;
              nonempty_d = 1'b0;
            end else if (!cls_i.is_space) begin
              bad = 1'b1;
            end
          end
          ModeValue: begin
            if (cls_i.is_nl) begin
              res.value_end = 1'b1;
              mode_d        = ModeLine;
              nonempty_d    = 1'b0;
            end else if (cls_i.is_bslash) begin
              mode_d = ModeEsc;
            end else if (nonempty_q || !cls_i.is_space) begin
              res.out_byte   = byte_i;
              res.byte_valid = 1'b1;
              nonempty_d     = 1'b1;
            end
          end
          ModeEsc: begin
            res.out_byte   = byte_i;
            res.byte_valid = 1'b1;
            nonempty_d     = 1'b1;
            mode_d         = ModeValue;
          end
          ModeComment: begin
            if (cls_i.is_nl) begin
              mode_d = ModeLine;
            end
          end
          default: begin
            if (cls_i.is_hash) begin
              mode_d = ModeComment;
            end else if (cls_i.is_key) begin
              res.out_byte   = byte_i;
              res.byte_valid = 1'b1;
              res.in_key     = 1'b1;
              res.key_start  = 1'b1;
              mode_d         = ModeKey;
            end else if (!cls_i.is_space) begin
              bad = 1'b1;
            end
          end
        endcase
      end
      if (bad) begin
        res        = '0;
        err_d      = 1'b1;
        mode_d     = mode_q;
        nonempty_d = nonempty_q;
      end
    end
    res.parse_error = err_d;
    res_o           = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeLine;
      nonempty_q <= 1'b0;
      err_q      <= 1'b0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      nonempty_q <= nonempty_d;
      err_q      <= err_d;
    end
  end

endmodule

// ===== sv/properties_text_tokenizer.sv =====
// Top level of the properties text tokenizer: input register, parser, result register.
// A request is held in the input register, passes the parser and is then registered in the result register.
// Throughput: one request per cycle while out_stall_i is low; the parser state updates once per request.
// The input stall follows the output stall only when both stages hold requests.
// Reset (rst_ni low, asynchronous) empties both stages and returns the parser to
// line start with the error flag clear.
module properties_text_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       cmd_i,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       in_key_o,
  output logic       key_start_o,
  output logic       key_part_end_o,
  output logic       key_end_o,
  output logic       value_end_o,
  output logic       parse_error_o
);

  logic            in_vld_q;
  logic            cmd_q;
  logic [7:0]      byte_q;
  logic            out_vld_q;
  ptt_pkg::res_t   res_q;
  ptt_pkg::res_t   res;
  ptt_pkg::class_t cls;
  logic            out_free;
  logic            step;
  logic            in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  ptt_classify u_classify (
    .byte_i (byte_q),
    .cls_o  (cls)
  );

  ptt_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cmd_i  (cmd_q),
    .byte_i (byte_q),
    .cls_i  (cls),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= step;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q  <= cmd_i;
      byte_q <= text_byte_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign out_byte_o     = res_q.out_byte;
  assign byte_valid_o   = res_q.byte_valid;
  assign in_key_o       = res_q.in_key;
  assign key_start_o    = res_q.key_start;
  assign key_part_end_o = res_q.key_part_end;
  assign key_end_o      = res_q.key_end;
  assign value_end_o    = res_q.value_end;
  assign parse_error_o  = res_q.parse_error;

endmodule

// ===== sv/ptt_checker.sv =====
// Port-level checker for the properties text tokenizer, bound to the top level.
module ptt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       byte_valid_o,
  input logic       in_key_o,
  input logic       key_start_o,
  input logic       key_part_end_o,
  input logic       key_end_o,
  input logic       value_end_o,
  input logic       parse_error_o
);

  logic err_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && parse_error_o) begin
      err_seen_q <= 1'b1;
    end
  end

  // error is sticky and silences all later requests
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && err_seen_q |-> parse_error_o && !byte_valid_o && !key_end_o &&
                                  !value_end_o)
    else $error("parse_error dropped or output after error");

  a_no_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> out_byte_o == 8'd0 && !in_key_o && !key_start_o)
    else $error("byte fields set without byte_valid");

  a_key_end_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && key_end_o |-> key_part_end_o && !value_end_o)
    else $error("key_end without key_part_end");

  a_value_end_nokey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_end_o |-> !in_key_o && !byte_valid_o)
    else $error("value_end with key or byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
                                   $stable(parse_error_o))
    else $error("stalled result changed");

endmodule

bind properties_text_tokenizer ptt_checker u_ptt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .byte_valid_o   (byte_valid_o),
  .in_key_o       (in_key_o),
  .key_start_o    (key_start_o),
  .key_part_end_o (key_part_end_o),
  .key_end_o      (key_end_o),
  .value_end_o    (value_end_o),
  .parse_error_o  (parse_error_o)
);

// ===== sim/tokenizer_checker.sv =====
// Checker for the properties text tokenizer: request monitor, token predictor, result compare.
module tokenizer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic       cmd_i,
  input  logic [7:0] text_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] out_byte_i,
  input  logic       byte_valid_i,
  input  logic       in_key_i,
  input  logic       key_start_i,
  input  logic       key_part_end_i,
  input  logic       key_end_i,
  input  logic       value_end_i,
  input  logic       parse_error_i,
  output int         mismatches_o,
  output int         outstanding_o,
  output int         n_results_o,
  output int         n_keys_o,
  output int         n_values_o
);

  typedef enum logic [2:0] {
    ModeLine, ModeKey, ModeKeySp, ModeValue, ModeEsc, ModeComment
  } mode_e;

  mode_e         mode_q;
  logic          nonempty_q;
  logic          err_q;
  ptt_pkg::res_t expected_tokens[$];

  function automatic logic is_name_char(input logic [7:0] ch);
    return (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") ||
           (ch >= "0" && ch <= "9") || ch == ptt_pkg::ChUnder;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == ptt_pkg::ChSpace || (ch >= 8'd9 && ch <= 8'd13);
  endfunction

  function automatic ptt_pkg::res_t tokenize_step(input logic cmd, input logic [7:0] ch);
    ptt_pkg::res_t r;
    logic bad;
    r   = '0;
    bad = 1'b0;
    if (!err_q) begin
      if (cmd == ptt_pkg::CmdEnd) begin
        if (mode_q == ModeValue || mode_q == ModeEsc) r.value_end = 1'b1;
        else if (mode_q == ModeKey || mode_q == ModeKeySp) bad = 1'b1;
        if (!bad) begin
          mode_q     = ModeLine;
          nonempty_q = 1'b0;
        end
      end else begin
        case (mode_q)
          ModeKey: begin
            if (ch == ptt_pkg::ChDot) begin
              r.key_part_end = 1'b1;
              r.out_byte     = ch;
              r.byte_valid   = 1'b1;
              r.in_key       = 1'b1;
            end else if (is_name_char(ch)) begin
              r.out_byte   = ch;
              r.byte_valid = 1'b1;
              r.in_key     = 1'b1;
            end else if (is_blank(ch)) begin
              r.key_part_end = 1'b1;
              r.key_end      = 1'b1;
              mode_q         = ModeKeySp;
            end else if (ch == ptt_pkg::ChEq) begin
              r.key_part_end = 1'b1;
              r.key_end      = 1'b1;
              mode_q         = ModeValue;
              nonempty_q     = 1'b0;
            end else begin
              bad = 1'b1;
            end
          end
          ModeKeySp: begin
            if (ch == ptt_pkg::ChEq) begin
              mode_q     = ModeValue;
              nonempty_q = 1'b0;
            end else if (!is_blank(ch)) begin
              bad = 1'b1;
            end
          end
          ModeValue: begin
            if (ch == ptt_pkg::ChNl) begin
              r.value_end = 1'b1;
              mode_q      = ModeLine;
              nonempty_q  = 1'b0;
            end else if (ch == ptt_pkg::ChBslash) begin
              mode_q = ModeEsc;
            end else if (nonempty_q || !is_blank(ch)) begin
              r.out_byte   = ch;
              r.byte_valid = 1'b1;
              nonempty_q   = 1'b1;
            end
          end
          ModeEsc: begin
            r.out_byte   = ch;
            r.byte_valid = 1'b1;
            nonempty_q   = 1'b1;
            mode_q       = ModeValue;
          end
          ModeComment: begin
            if (ch == ptt_pkg::ChNl) mode_q = ModeLine;
          end
          default: begin
            if (ch == ptt_pkg::ChHash) begin
              mode_q = ModeComment;
            end else if (is_name_char(ch)) begin
              r.out_byte   = ch;
              r.byte_valid = 1'b1;
              r.in_key     = 1'b1;
              r.key_start  = 1'b1;
              mode_q       = ModeKey;
            end else if (!is_blank(ch)) begin
              bad = 1'b1;
            end
          end
        endcase
      end
      if (bad) begin
        err_q = 1'b1;
        r     = '0;
      end
    end
    r.parse_error = err_q;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    mismatches_o++;
    if (mismatches_o <= 40)
      $display("mismatch on result %0d, %s: got %0h, expected %0h",
               n_results_o, what, got, want);
  endtask

  task automatic cmp_field(input string what, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report(what, int'(got), int'(want));
  endtask

  task automatic cmp_bit(input string what, input logic got, input logic want);
    if (got !== want) report(what, int'(got), int'(want));
  endtask

  initial begin
    mismatches_o = 0;
    n_results_o  = 0;
    n_keys_o     = 0;
    n_values_o   = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    ptt_pkg::res_t want;
    if (!rst_ni) begin
      mode_q     = ModeLine;
      nonempty_q = 1'b0;
      err_q      = 1'b0;
      expected_tokens.delete();
      outstanding_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_tokens.push_back(tokenize_step(cmd_i, text_byte_i));
      if (out_valid_i && !out_stall_i) begin
        n_results_o++;
        if (key_start_i === 1'b1) n_keys_o++;
        if (value_end_i === 1'b1) n_values_o++;
        if (expected_tokens.size() == 0) begin
          report("result with no request pending", int'(out_byte_i), 0);
        end else begin
          want = expected_tokens.pop_front();
          cmp_field("out_byte", out_byte_i, want.out_byte);
          cmp_bit("byte_valid", byte_valid_i, want.byte_valid);
          cmp_bit("in_key", in_key_i, want.in_key);
          cmp_bit("key_start", key_start_i, want.key_start);
          cmp_bit("key_part_end", key_part_end_i, want.key_part_end);
          cmp_bit("key_end", key_end_i, want.key_end);
          cmp_bit("value_end", value_end_i, want.value_end);
          cmp_bit("parse_error", parse_error_i, want.parse_error);
        end
      end
      outstanding_o <= expected_tokens.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the properties text tokenizer: clock, reset, request stimulus, verdict.
module tb;

  localparam int Limit   = 200000;
  localparam int NumRand = 800;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       cmd_i;
  logic [7:0] text_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       in_key_o;
  logic       key_start_o;
  logic       key_part_end_o;
  logic       key_end_o;
  logic       value_end_o;
  logic       parse_error_o;

  int   mismatches;
  int   outstanding;
  int   n_results;
  int   n_keys;
  int   n_values;
  int   n_sent;
  int   cycles;
  logic calm;

  string NameChars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";

  properties_text_tokenizer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .text_byte_i   (text_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .byte_valid_o  (byte_valid_o),
    .in_key_o      (in_key_o),
    .key_start_o   (key_start_o),
    .key_part_end_o(key_part_end_o),
    .key_end_o     (key_end_o),
    .value_end_o   (value_end_o),
    .parse_error_o (parse_error_o)
  );

  tokenizer_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .cmd_i         (cmd_i),
    .text_byte_i   (text_byte_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_i    (out_byte_o),
    .byte_valid_i  (byte_valid_o),
    .in_key_i      (in_key_o),
    .key_start_i   (key_start_o),
    .key_part_end_i(key_part_end_o),
    .key_end_i     (key_end_o),
    .value_end_i   (value_end_o),
    .parse_error_i (parse_error_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .n_results_o   (n_results),
    .n_keys_o      (n_keys),
    .n_values_o    (n_values)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = ptt_pkg::CmdByte;
    text_byte_i = 8'h00;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    n_sent      = 0;
    cycles      = 0;
  end

  always @(posedge clk_i) out_stall_i <= !calm && ($urandom_range(0, 99) < 6);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= c;
    text_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ptt_pkg::CmdByte, s[i]);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [7:0] pick_blank(input bit allow_nl);
    int v;
    v = $urandom_range(9, 14);
    if (v == 14 || (!allow_nl && v == 10)) v = 32;
    return v[7:0];
  endfunction

  // Any byte but newline and backslash.
  function automatic logic [7:0] pick_plain();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ptt_pkg::ChNl || b == ptt_pkg::ChBslash) b = ptt_pkg::ChSpace;
    return b;
  endfunction

  task automatic send_key();
    int parts;
    parts = $urandom_range(1, 3);
    for (int i = 0; i < parts; i++) begin
      if (i > 0) send_item(ptt_pkg::CmdByte, ptt_pkg::ChDot);
      repeat ($urandom_range(1, 6))
        send_item(ptt_pkg::CmdByte, NameChars[$urandom_range(0, NameChars.len() - 1)]);
    end
    if ($urandom_range(0, 9) == 0) send_item(ptt_pkg::CmdByte, ptt_pkg::ChDot);
  endtask

  task automatic send_entry();
    send_key();
    repeat ($urandom_range(0, 2)) send_item(ptt_pkg::CmdByte, pick_blank(1));
    send_item(ptt_pkg::CmdByte, ptt_pkg::ChEq);
    repeat ($urandom_range(0, 2)) send_item(ptt_pkg::CmdByte, pick_blank(0));
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(ptt_pkg::CmdByte, ptt_pkg::ChBslash);
        send_item(ptt_pkg::CmdByte, 8'($urandom_range(0, 255)));
      end else begin
        send_item(ptt_pkg::CmdByte, pick_plain());
      end
    end
    if ($urandom_range(0, 7) == 0) send_item(ptt_pkg::CmdEnd, 8'($urandom_range(0, 255)));
    else send_item(ptt_pkg::CmdByte, ptt_pkg::ChNl);
  endtask

  task automatic send_comment();
    send_item(ptt_pkg::CmdByte, ptt_pkg::ChHash);
    repeat ($urandom_range(0, 8)) send_item(ptt_pkg::CmdByte, pick_plain());
    if ($urandom_range(0, 5) == 0) send_item(ptt_pkg::CmdEnd, 8'($urandom_range(0, 255)));
    else send_item(ptt_pkg::CmdByte, ptt_pkg::ChNl);
  endtask

  task automatic send_blank_line();
    repeat ($urandom_range(0, 3)) send_item(ptt_pkg::CmdByte, pick_blank(1));
    if ($urandom_range(0, 3) == 0) send_item(ptt_pkg::CmdEnd, 8'($urandom_range(0, 255)));
    else send_item(ptt_pkg::CmdByte, ptt_pkg::ChNl);
  endtask

  // One way into the sticky error, then noise that must be ignored.
  task automatic send_error_tail();
    case ($urandom_range(0, 4))
      0: send_text("ab!");
      1: begin
        send_text("ab");
        send_item(ptt_pkg::CmdEnd, 8'h00);
      end
      2: begin
        send_text("ab ");
        send_item(ptt_pkg::CmdEnd, 8'h00);
      end
      3: send_text("ab x");
      default: send_item(ptt_pkg::CmdByte, 8'($urandom_range(128, 255)));
    endcase
    repeat (20) send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int  base;
    int  pick;
    logic drained;
    drained = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // comment and line start closed by end of input
    send_text("#c");
    send_item(ptt_pkg::CmdByte, 8'hFF);
    send_item(ptt_pkg::CmdEnd, 8'h00);
    send_item(ptt_pkg::CmdEnd, 8'hA5);
    // dotted key straight into '=', leading blanks dropped, dangling escape
    send_text(" z0.A_=");
    send_text("  v\\");
    send_item(ptt_pkg::CmdEnd, 8'h00);
    // newline between key and '=', escaped newline, high byte, trailing blank kept
    send_text("k\n=\\\n");
    send_item(ptt_pkg::CmdByte, 8'h80);
    send_text(" \n");
    send_text("9=");
    send_item(ptt_pkg::CmdEnd, 8'h5A);

    base = n_sent;
    while (n_sent < base + NumRand) begin
      calm = (n_sent >= base + 200) && (n_sent < base + 400);
      if (!drained && n_sent >= base + 400) begin
        wait_for_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) send_entry();
      else if (pick < 85) send_comment();
      else send_blank_line();
    end
    calm = 1'b0;
    send_error_tail();

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("Summary: %0d requests sent, %0d results checked", n_sent, n_results);
    $display("Summary: %0d keys started, %0d values closed, run ends in error state",
             n_keys, n_values);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
